[rtl/core/fpba_pkg.sv]
// ============================================================================
// fpba_pkg - fit-policy block allocator shared types and constants
// Table depth, alignment, request modes and status codes.
// ============================================================================
package fpba_pkg;

	localparam int MaxBlocks = 16;
	localparam int IdxW      = $clog2(MaxBlocks);
	localparam int CntW      = $clog2(MaxBlocks + 1);
	localparam int AlignBytes = 8;
	localparam int AlignW    = $clog2(AlignBytes);

	typedef enum logic [2:0] {
		MODE_APPEND_USED = 3'd0,
		MODE_APPEND_FREE = 3'd1,
		MODE_FIRST_FIT   = 3'd2,
		MODE_NEXT_FIT    = 3'd3,
		MODE_BEST_FIT    = 3'd4,
		MODE_FREE        = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FIT  = 2'd1,
		ST_BAD_ADR = 2'd2,
		ST_NO_ROOM = 2'd3
	} status_t;

	localparam logic [0:0] REG_HEADER = 1'b0;
	localparam logic [0:0] REG_SPLIT  = 1'b1;

	// entry as held in the table memory: used mark and total size
	typedef struct packed {
		logic        used;
		logic [15:0] size;
	} entry_t;

endpackage

[rtl/core/fit_policy_block_allocator.sv]
// Requests are handled one at a time; a table pass reads and checks one entry
// at a time. A held result only delays the completion of the following request.
// Reset: asynchronous; count, cursor, registers and result port return to defaults.
// Table entries at or beyond the count are never read, so no clearing pass is needed.
// ============================================================================
// fit_policy_block_allocator - table-based heap block allocator
// Append, first/next/best fit allocation with split, and free with merging.
// ============================================================================
module fit_policy_block_allocator
	import fpba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [15:0] payload_bytes,
	input  logic [15:0] block_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] result_addr,
	output logic [15:0] result_bytes
);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
		S_GRANT, S_SPLIT, S_MERGE_RD, S_MERGE_CHK, S_MERGE_END, S_DONE
	} state_t;

	// table memory: one write port, one registered read port
	entry_t             mem [MaxBlocks];
	logic [IdxW-1:0]    rd_idx;
	logic               rd_en;
	entry_t             rd_q;
	logic               wr_en;
	logic [IdxW-1:0]    wr_idx;
	entry_t             wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		if (rd_en) rd_q <= mem[rd_idx];
	end

	state_t          state_q;
	logic [6:0]      header_q;
	logic [7:0]      split_q;
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] cursor_q;
	logic [15:0]     total_q;
	logic [2:0]      mode_q;
	logic [15:0]     pay_q;
	logic [15:0]     addr_q;
	logic [CntW-1:0] k_q;
	logic [15:0]     acc_q;
	logic            found_q;
	logic [IdxW-1:0] pick_q;
	logic [15:0]     pick_addr_q;
	logic [15:0]     pick_size_q;
	logic [16:0]     best_q;
	logic            lo_found_q;
	logic [IdxW-1:0] lo_idx_q;
	logic [15:0]     lo_addr_q;
	logic [15:0]     lo_size_q;
	logic            split_do_q;
	logic [15:0]     net_q;
	logic [CntW-1:0] j_q;
	logic [IdxW-1:0] w_q;
	entry_t          held_q;
	logic [1:0]      res_st_q;
	logic [15:0]     res_addr_q;
	logic [15:0]     res_bytes_q;
	logic [1:0]      st_q;
	logic [15:0]     raddr_q;
	logic [15:0]     rbytes_q;
	logic            ovalid_q;

	// combinational helpers
	logic [16:0]     rnd_pay;
	logic [17:0]     app_sz;
	logic            app_room;
	logic [16:0]     need;
	logic            fit_now;
	logic [16:0]     left_now;
	logic [CntW-1:0] nf_first;
	logic            g_found;
	logic [IdxW-1:0] g_idx;
	logic [15:0]     g_addr;
	logic [15:0]     g_size;
	logic            g_split;
	logic            shift_end;
	entry_t          mrg_ent;
	logic            merge_pair;
	logic            out_take;
	logic            done_load;

	assign rnd_pay  = (({1'b0, pay_q} + 17'(AlignBytes - 1)) >> AlignW) << AlignW;
	assign app_sz   = {1'b0, rnd_pay} + 18'(header_q);
	assign app_room = (count_q < CntW'(MaxBlocks)) && (app_sz <= 18'd65535) &&
	                  ({2'b0, total_q} + app_sz <= 18'd65535);
	assign need     = {1'b0, pay_q} + 17'(header_q);
	assign fit_now  = !rd_q.used && ({1'b0, rd_q.size} >= need);
	assign left_now = {1'b0, rd_q.size} - need;
	assign nf_first = (CntW'(cursor_q) < count_q) ? CntW'(cursor_q) : '0;

	// grant candidate: next fit falls back to the wrapped part of the scan
	always_comb begin
		if (mode_q == MODE_NEXT_FIT && !found_q) begin
			g_found = lo_found_q;
			g_idx   = lo_idx_q;
			g_addr  = lo_addr_q;
			g_size  = lo_size_q;
		end else begin
			g_found = found_q;
			g_idx   = pick_q;
			g_addr  = pick_addr_q;
			g_size  = pick_size_q;
		end
	end

	assign g_split = ({2'b0, g_size} > app_sz) &&
	                 (({2'b0, g_size} - app_sz) >= 18'(split_q)) &&
	                 (count_q < CntW'(MaxBlocks));

	assign shift_end = (j_q <= CntW'(pick_q) + 1'b1);

	// entry as seen by the merge pass, freed block already marked free
	always_comb begin
		mrg_ent = rd_q;
		if (IdxW'(k_q) == pick_q) mrg_ent.used = 1'b0;
	end
	assign merge_pair = !held_q.used && !mrg_ent.used;

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = ovalid_q;
	assign status       = st_q;
	assign result_addr  = raddr_q;
	assign result_bytes = rbytes_q;

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_idx  = IdxW'(k_q);
		wr_en   = 1'b0;
		wr_idx  = w_q;
		wr_data = held_q;
		unique case (state_q)
			S_SCAN_RD:  rd_en = (k_q != count_q);
			S_DECIDE: begin
				// append is a single write
				if (mode_q <= MODE_APPEND_FREE && app_room) begin
					wr_en   = 1'b1;
					wr_idx  = IdxW'(count_q);
					wr_data = '{used: (mode_q == MODE_APPEND_USED), size: app_sz[15:0]};
				end
			end
			S_SHIFT_RD: begin
				if (!shift_end) begin
					rd_en  = 1'b1;
					rd_idx = IdxW'(j_q - 1'b1);
				end
			end
			S_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_idx  = IdxW'(j_q);
				wr_data = rd_q;
			end
			S_GRANT: begin
				wr_en   = 1'b1;
				wr_idx  = pick_q;
				wr_data = '{used: 1'b1, size: split_do_q ? net_q : pick_size_q};
			end
			S_SPLIT: begin
				wr_en   = 1'b1;
				wr_idx  = pick_q + 1'b1;
				wr_data = '{used: 1'b0, size: pick_size_q - net_q};
			end
			S_MERGE_RD:  rd_en = (k_q != count_q);
			S_MERGE_CHK: wr_en = (k_q != '0) && !merge_pair;
			S_MERGE_END: wr_en = 1'b1;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			header_q    <= 7'd24;
			split_q     <= 8'd24;
			count_q     <= '0;
			cursor_q    <= '0;
			total_q     <= '0;
			mode_q      <= '0;
			pay_q       <= '0;
			addr_q      <= '0;
			k_q         <= '0;
			acc_q       <= '0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			pick_addr_q <= '0;
			pick_size_q <= '0;
			best_q      <= '0;
			lo_found_q  <= 1'b0;
			lo_idx_q    <= '0;
			lo_addr_q   <= '0;
			lo_size_q   <= '0;
			split_do_q  <= 1'b0;
			net_q       <= '0;
			j_q         <= '0;
			w_q         <= '0;
			held_q      <= '0;
			res_st_q    <= ST_OK;
			res_addr_q  <= '0;
			res_bytes_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_HEADER) header_q <= cfg_wdata[6:0];
				else split_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						mode_q      <= mode;
						pay_q       <= payload_bytes;
						addr_q      <= block_addr;
						k_q         <= '0;
						acc_q       <= '0;
						found_q     <= 1'b0;
						lo_found_q  <= 1'b0;
						best_q      <= '0;
						res_st_q    <= ST_OK;
						res_addr_q  <= '0;
						res_bytes_q <= '0;
						state_q     <= (mode <= MODE_APPEND_FREE) ? S_DECIDE :
						               (mode <= MODE_FREE) ? S_SCAN_RD : S_DONE;
					end
				end
				S_SCAN_RD: begin
					state_q <= (k_q == count_q) ? S_DECIDE : S_SCAN_CHK;
				end
				// one entry per read: track its start and the candidate so far
				S_SCAN_CHK: begin
					k_q     <= k_q + 1'b1;
					acc_q   <= acc_q + rd_q.size;
					state_q <= S_SCAN_RD;
					if (mode_q == MODE_FREE) begin
						if (!found_q && acc_q == addr_q && rd_q.used) begin
							found_q     <= 1'b1;
							pick_q      <= IdxW'(k_q);
							pick_size_q <= rd_q.size;
							pick_addr_q <= acc_q;
						end
					end else if (mode_q == MODE_BEST_FIT) begin
						if (fit_now && (!found_q || left_now < best_q)) begin
							found_q     <= 1'b1;
							best_q      <= left_now;
							pick_q      <= IdxW'(k_q);
							pick_size_q <= rd_q.size;
							pick_addr_q <= acc_q;
						end
					end else if (mode_q == MODE_NEXT_FIT && k_q < nf_first) begin
						// ahead of the cursor: only used once the scan wraps
						if (fit_now && !lo_found_q) begin
							lo_found_q <= 1'b1;
							lo_idx_q   <= IdxW'(k_q);
							lo_size_q  <= rd_q.size;
							lo_addr_q  <= acc_q;
						end
					end else begin
						if (fit_now && !found_q) begin
							found_q     <= 1'b1;
							pick_q      <= IdxW'(k_q);
							pick_size_q <= rd_q.size;
							pick_addr_q <= acc_q;
						end
					end
				end
				S_DECIDE: begin
					if (mode_q <= MODE_APPEND_FREE) begin
						if (app_room) begin
							count_q     <= count_q + 1'b1;
							total_q     <= total_q + app_sz[15:0];
							res_addr_q  <= total_q;
							res_bytes_q <= app_sz[15:0];
						end else begin
							res_st_q <= ST_NO_ROOM;
						end
						state_q <= S_DONE;
					end else if (mode_q == MODE_FREE) begin
						if (found_q) begin
							res_addr_q  <= pick_addr_q;
							res_bytes_q <= pick_size_q;
							k_q         <= '0;
							w_q         <= '0;
							state_q     <= S_MERGE_RD;
						end else begin
							res_st_q <= ST_BAD_ADR;
							state_q  <= S_DONE;
						end
					end else if (g_found) begin
						pick_q      <= g_idx;
						pick_size_q <= g_size;
						split_do_q  <= g_split;
						net_q       <= app_sz[15:0];
						cursor_q    <= g_idx;
						res_addr_q  <= g_addr;
						res_bytes_q <= g_split ? app_sz[15:0] : g_size;
						j_q         <= count_q;
						state_q     <= g_split ? S_SHIFT_RD : S_GRANT;
					end else begin
						res_st_q <= ST_NO_FIT;
						state_q  <= S_DONE;
					end
				end
				// open a slot after the pick, moving the tail up from the top
				S_SHIFT_RD: begin
					state_q <= shift_end ? S_GRANT : S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					j_q     <= j_q - 1'b1;
					state_q <= S_SHIFT_RD;
				end
				S_GRANT: begin
					state_q <= split_do_q ? S_SPLIT : S_DONE;
				end
				S_SPLIT: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				// merge sweep: held entry at w absorbs free neighbours
				S_MERGE_RD: begin
					state_q <= (k_q == count_q) ? S_MERGE_END : S_MERGE_CHK;
				end
				S_MERGE_CHK: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_MERGE_RD;
					if (k_q == '0) begin
						held_q <= mrg_ent;
					end else if (merge_pair) begin
						held_q.size <= held_q.size + mrg_ent.size;
						if (cursor_q == w_q)
							cursor_q <= (w_q != '0) ? w_q - 1'b1 : '0;
						else if (CntW'(cursor_q) == CntW'(w_q) + 1'b1)
							cursor_q <= w_q;
						else if (CntW'(cursor_q) > CntW'(w_q) + 1'b1)
							cursor_q <= cursor_q - 1'b1;
					end else begin
						w_q    <= w_q + 1'b1;
						held_q <= mrg_ent;
					end
				end
				S_MERGE_END: begin
					count_q <= CntW'(w_q) + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!ovalid_q || !out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register: loaded once the previous result has left
	assign out_take  = ovalid_q && !out_stall;
	assign done_load = (state_q == S_DONE) && (!ovalid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			st_q     <= ST_OK;
			raddr_q  <= '0;
			rbytes_q <= '0;
		end else if (done_load) begin
			ovalid_q <= 1'b1;
			st_q     <= res_st_q;
			raddr_q  <= res_addr_q;
			rbytes_q <= res_bytes_q;
		end else if (out_take) begin
			ovalid_q <= 1'b0;
		end
	end

endmodule

[sim/fit_policy_block_allocator_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// fit_policy_block_allocator_test - self-checking bench for the block allocator
// Drives appends, first/next/best fit allocations and frees under several
// idling phases and register settings. A behavioural model of the block table
// predicts every result, and each returned result is checked against it.
// ============================================================================
module fit_policy_block_allocator_test;
	import fpba_pkg::*;

	localparam int NBLK = MaxBlocks;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] addr;
		logic [15:0] bytes;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  mode;
	logic [15:0] payload_bytes;
	logic [15:0] block_addr;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [15:0] result_addr;
	logic [15:0] result_bytes;

	fit_policy_block_allocator uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .payload_bytes(payload_bytes), .block_addr(block_addr),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.result_addr(result_addr), .result_bytes(result_bytes)
	);

	// model state
	int unsigned   hdr_bytes;
	int unsigned   split_bytes;
	int unsigned   blk_size [NBLK];
	bit            blk_used [NBLK];
	int unsigned   blk_count;
	int unsigned   cursor;

	alloc_result_t pending_results[$];
	int            error_count;
	int            results_seen;
	int            send_idle_pct;
	int            recv_stall_pct;
	bit            hold_off;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// overall limit
	initial begin
		#80ms;
		$display("Timeout at %0t", $time);
		$display("FAILURE");
		$finish;
	end

	function automatic int unsigned round_up(int unsigned p);
		return ((p + 7) / 8) * 8;
	endfunction

	function automatic int unsigned start_addr(int unsigned idx);
		int unsigned a;
		a = 0;
		for (int i = 0; i < idx && i < blk_count; i++) a += blk_size[i];
		return a;
	endfunction

	function automatic bit block_fits(int unsigned i, int unsigned p);
		return !blk_used[i] && blk_size[i] >= hdr_bytes + p;
	endfunction

	function automatic alloc_result_t grant_block(int unsigned i, int unsigned p);
		int unsigned net, sz;
		alloc_result_t r;
		net = hdr_bytes + round_up(p);
		sz  = blk_size[i];
		if (sz > net && sz - net >= split_bytes && blk_count < NBLK) begin
			for (int j = blk_count; j > i + 1; j--) begin
				blk_size[j] = blk_size[j-1];
				blk_used[j] = blk_used[j-1];
			end
			blk_size[i+1] = sz - net;
			blk_used[i+1] = 1'b0;
			blk_size[i]   = net;
			blk_count++;
		end
		blk_used[i] = 1'b1;
		cursor = i;
		r.status = ST_OK;
		r.addr   = 16'(start_addr(i));
		r.bytes  = 16'(blk_size[i]);
		return r;
	endfunction

	function automatic void merge_free_blocks();
		int unsigned i;
		i = 0;
		while (i + 1 < blk_count) begin
			if (!blk_used[i] && !blk_used[i+1]) begin
				blk_size[i] += blk_size[i+1];
				for (int j = i + 1; j + 1 < blk_count; j++) begin
					blk_size[j] = blk_size[j+1];
					blk_used[j] = blk_used[j+1];
				end
				blk_count--;
				blk_size[blk_count] = 0;
				blk_used[blk_count] = 1'b0;
				if (cursor == i) cursor = (i > 0) ? i - 1 : 0;
				else if (cursor == i + 1) cursor = i;
				else if (cursor > i + 1) cursor--;
			end else begin
				i++;
			end
		end
	endfunction

	// predict the result of one request and update the model table
	function automatic alloc_result_t predict_alloc(logic [2:0] m, int unsigned p,
			int unsigned a);
		alloc_result_t r;
		int unsigned sz, total, first, k, pick, best, left, pos;
		bit found;
		r = '0;
		case (m)
			MODE_APPEND_USED, MODE_APPEND_FREE: begin
				sz = hdr_bytes + round_up(p);
				total = start_addr(blk_count);
				if (blk_count >= NBLK || sz > 65535 || total + sz > 65535) begin
					r.status = ST_NO_ROOM;
				end else begin
					blk_size[blk_count] = sz;
					blk_used[blk_count] = (m == MODE_APPEND_USED);
					blk_count++;
					r.addr  = 16'(total);
					r.bytes = 16'(sz);
				end
			end
			MODE_FIRST_FIT: begin
				r.status = ST_NO_FIT;
				for (int i = 0; i < blk_count; i++)
					if (block_fits(i, p)) begin
						r = grant_block(i, p);
						break;
					end
			end
			MODE_NEXT_FIT: begin
				r.status = ST_NO_FIT;
				first = (cursor < blk_count) ? cursor : 0;
				for (k = 0; k < blk_count; k++) begin
					pos = (first + k) % blk_count;
					if (block_fits(pos, p)) begin
						r = grant_block(pos, p);
						break;
					end
				end
			end
			MODE_BEST_FIT: begin
				found = 1'b0;
				pick = 0;
				best = 0;
				for (int i = 0; i < blk_count; i++)
					if (block_fits(i, p)) begin
						left = blk_size[i] - hdr_bytes - p;
						if (!found || left < best) begin
							found = 1'b1;
							best = left;
							pick = i;
						end
					end
				if (found) r = grant_block(pick, p);
				else r.status = ST_NO_FIT;
			end
			MODE_FREE: begin
				r.status = ST_BAD_ADR;
				pos = 0;
				for (int i = 0; i < blk_count; i++) begin
					if (pos == a && blk_used[i]) begin
						r.status = ST_OK;
						r.addr   = 16'(pos);
						r.bytes  = 16'(blk_size[i]);
						blk_used[i] = 1'b0;
						merge_free_blocks();
						break;
					end
					pos += blk_size[i];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d addr %0d bytes %0d",
					$time, status, result_addr, result_bytes);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, status);
					error_count++;
				end
				if (result_addr !== exp_r.addr) begin
					$display("%0t: result_addr expected %0d actual %0d", $time,
						exp_r.addr, result_addr);
					error_count++;
				end
				if (result_bytes !== exp_r.bytes) begin
					$display("%0t: result_bytes expected %0d actual %0d", $time,
						exp_r.bytes, result_bytes);
					error_count++;
				end
			end
		end
	end

	// send one request, with random idle cycles before it
	task automatic send_request(logic [2:0] m, logic [15:0] p, logic [15:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			@(posedge clk);
			in_valid <= 1'b0;
		end
		@(posedge clk);
		in_valid      <= 1'b1;
		mode          <= m;
		payload_bytes <= p;
		block_addr    <= a;
		pending_results.push_back(predict_alloc(m, p, a));
		do @(posedge clk); while (in_stall);
		in_valid <= 1'b0;
	endtask

	// wait for all results, then a settling pause
	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HEADER) hdr_bytes = val & 8'h7f;
		else split_bytes = val;
	endtask

	// address of a random block, mostly a real block start
	function automatic logic [15:0] pick_addr();
		if (blk_count != 0 && $urandom_range(9) < 8)
			return 16'(start_addr($urandom_range(blk_count - 1)));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_payload();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'($urandom_range(7));
			default: return 16'($urandom_range(600));
		endcase
	endfunction

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_request(MODE_FIRST_FIT, 16'd8, 16'd0);     // empty table
		send_request(MODE_NEXT_FIT, 16'd0, 16'd0);
		send_request(MODE_BEST_FIT, 16'd0, 16'd0);
		send_request(MODE_FREE, 16'd0, 16'd0);          // nothing used
		send_request(MODE_APPEND_FREE, 16'd1000, 16'd0);
		send_request(MODE_APPEND_USED, 16'd0, 16'd0);
		send_request(MODE_APPEND_FREE, 16'd200, 16'd0);
		send_request(MODE_APPEND_USED, 16'd65535, 16'd0); // no room
		send_request(MODE_FIRST_FIT, 16'd100, 16'd0);   // split
		send_request(MODE_BEST_FIT, 16'd150, 16'd0);    // best over first
		send_request(MODE_NEXT_FIT, 16'd50, 16'd0);
		send_request(MODE_FIRST_FIT, 16'd60000, 16'd0); // no fit
		send_request(3'd6, 16'hffff, 16'hffff);          // unused mode
		send_request(3'd7, 16'd0, 16'd0);
		send_request(MODE_FREE, 16'd0, 16'd0);           // free first block
		send_request(MODE_FREE, 16'd0, 16'd0);           // already free
		send_request(MODE_FREE, 16'hffff, 16'hffff);
		send_request(MODE_FREE, 16'd0, 16'(start_addr(1))); // merge chain
		drain();
	endtask

	// fill the table to its depth, then allocate with no split
	task automatic test_full_table();
		for (int i = 0; i < NBLK + 1; i++)
			send_request((i % 2) ? MODE_APPEND_USED : MODE_APPEND_FREE, 16'd64, 16'd0);
		send_request(MODE_FIRST_FIT, 16'd8, 16'd0);
		send_request(MODE_NEXT_FIT, 16'd8, 16'd0);
		send_request(MODE_BEST_FIT, 16'd8, 16'd0);
		drain();
	endtask

	// mostly well formed allocation traffic with random content
	task automatic test_random(int n);
		int unsigned pick;
		logic [2:0] m;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 12) m = MODE_APPEND_FREE;
			else if (pick < 18) m = MODE_APPEND_USED;
			else if (pick < 33) m = MODE_FIRST_FIT;
			else if (pick < 48) m = MODE_NEXT_FIT;
			else if (pick < 63) m = MODE_BEST_FIT;
			else if (pick < 97) m = MODE_FREE;
			else m = 3'($urandom_range(7));
			// clear a long-lived table now and then
			if (m == MODE_APPEND_FREE && blk_count == NBLK && $urandom_range(3) == 0)
				m = MODE_FREE;
			send_request(m, pick_payload(),
				(m == MODE_FREE) ? pick_addr() : 16'($urandom));
		end
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure();
		fork
			begin
				hold_off <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off <= 1'b0;
			end
			test_random(20);
		join
		drain();
	endtask

	task automatic test_phases();
		int idle_set [4] = '{0, 69, 0, 17};
		int stall_set[4] = '{0, 0, 69, 17};
		logic [7:0] hdr_set  [4] = '{8'd24, 8'd8, 8'd64, 8'd37};
		logic [7:0] split_set[4] = '{8'd0, 8'd255, 8'd24, 8'd9};
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_HEADER, hdr_set[ph]);
			write_reg(REG_SPLIT, split_set[ph]);
			send_idle_pct  = idle_set[ph];
			recv_stall_pct = stall_set[ph];
			test_random(150);
			// header change with blocks present
			drain();
			write_reg(REG_HEADER, 8'(8 + $urandom_range(56)));
			test_random(150);
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = 8'd0;
		in_valid = 1'b0;
		mode = 3'd0;
		payload_bytes = 16'd0;
		block_addr = 16'd0;
		hold_off = 1'b0;
		error_count = 0;
		results_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hdr_bytes = 24;
		split_bytes = 24;
		blk_count = 0;
		cursor = 0;
		for (int i = 0; i < NBLK; i++) begin
			blk_size[i] = 0;
			blk_used[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_table();
		test_backpressure();
		test_phases();
		drain();

		$display("Covered appends, three fit policies, frees with merging, full table,");
		$display("register extremes and idle/stall phases; %0d results checked",
			results_seen);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
